// ===== rtl/dia_pkg.sv =====
`timescale 1ns / 1ps

package dia_pkg;

  // Slot index width, fixed by the request and response fields
  localparam int unsigned IDX_W = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0] IDX_ALL_ONES = {IDX_W{1'b1}};
  localparam logic [IDX_W-1:0] HEAP_CAPACITY_RST = IDX_W'(1024);
  localparam logic [IDX_W-1:0] RESERVED_COUNT_RST = IDX_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_CAPACITY  = 2'd0,
    CFG_RESERVED_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXHAUSTED    = 2'd1,
    ST_FREE_IGNORED = 2'd2,
    ST_LIST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] count;
    logic [IDX_W-1:0] base_index;
  } dia_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] alloc_base;
    logic [1:0]       status;
  } dia_rsp_t;

  // One free block held by a cell
  typedef struct packed {
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] size;
  } entry_t;

  // Signals rippling along the row of cells
  typedef struct packed {
    logic found;  // a fitting cell lies at or before this point
    logic shift;  // an exact fit was removed at or before this point
  } chain_t;

  // Common control broadcast to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             upd_alloc;
    logic             upd_free;
    logic [IDX_W-1:0] count;
    logic [IDX_W-1:0] free_base;
  } cell_ctrl_t;

endpackage

// ===== rtl/dia_cell.sv =====
`timescale 1ns / 1ps

module dia_cell
  import dia_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       listed_i,
  input  logic       append_i,
  input  entry_t     entry_next_i,
  input  chain_t     chain_i,
  output chain_t     chain_o,
  output entry_t     entry_o,
  output logic       first_o,
  output logic       exact_o
);

  entry_t entry_q, entry_d;
  logic   fit_q, fit_d;
  logic   first;
  logic   exact;

  // First-fit pick: ripple the found flag, the first fitting cell wins
  assign exact   = (entry_q.size == ctrl_i.count);
  assign first   = fit_q & ~chain_i.found;
  assign chain_o.found = chain_i.found | fit_q;
  assign chain_o.shift = chain_i.shift | (first & exact);

  assign entry_o = entry_q;
  assign first_o = first;
  assign exact_o = exact;

  // Compare against the request, registered for the update cycle
  always_comb begin
    fit_d = fit_q;
    if (ctrl_i.cmp_en) begin
      fit_d = listed_i & (entry_q.size >= ctrl_i.count);
    end
  end

  // Entry update: close up behind a removed block, trim a larger one, or append
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.upd_alloc) begin
      if (chain_o.shift) begin
        entry_d = entry_next_i;
      end else if (first) begin
        entry_d.base = entry_q.base + ctrl_i.count;
        entry_d.size = entry_q.size - ctrl_i.count;
      end
    end
    if (ctrl_i.upd_free && append_i) begin
      entry_d.base = ctrl_i.free_base;
      entry_d.size = ctrl_i.count;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    fit_q   <= fit_d;
  end

endmodule

// ===== rtl/descriptor_index_allocator.sv =====
`timescale 1ns / 1ps
// Channel  | Signals                              | Direction
// request  | in_valid_i, in_stall_o, in_req_i     | in
// response | out_valid_o, out_stall_i, out_rsp_o  | out
// config   | cfg_we_i, cfg_idx_i, cfg_data_i      | in, write only
//
// On acceptance every cell of the free list registers a size compare; in the
// update state S_UPD, once the response register can take a result, the block
// applies the first-fit pick, the close-up shift or the bump pointer, and loads the response register.
// Reset empties the free list and loads the bump pointer with reserved_count.
// A stalled response holds the update cycle; one further request may be taken
// while a response waits.

module descriptor_index_allocator
  import dia_pkg::*;
#(
  parameter int unsigned FREE_SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dia_req_t             in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dia_rsp_t             out_rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [IDX_W-1:0]     cfg_data_i
);

  localparam int unsigned LEN_W = $clog2(FREE_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  dia_req_t         req_q;
  dia_rsp_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W:0]   bump_q, bump_d;
  logic [IDX_W-1:0] cap_q, rsv_q;

  logic             accept;
  logic             go;
  logic             is_alloc;
  logic [IDX_W+1:0] bump_sum;
  logic             any_fit;
  logic             exact_sel;
  logic [IDX_W-1:0] sel_base;
  cell_ctrl_t       ctrl;

  entry_t                entry  [FREE_SLOTS];
  chain_t                chain  [FREE_SLOTS+1];
  logic [FREE_SLOTS-1:0] first_vec;
  logic [FREE_SLOTS-1:0] exact_vec;

  assign accept   = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign go       = (state_q == S_UPD) & (~out_valid_q | ~out_stall_i);
  assign is_alloc = (req_q.req_type == REQ_ALLOC);

  // Broadcast control to the cells
  always_comb begin
    ctrl.cmp_en    = accept;
    ctrl.upd_alloc = go & is_alloc;
    ctrl.upd_free  = go & ~is_alloc & (req_q.base_index != IDX_ALL_ONES)
                     & (req_q.count != '0) & (len_q < LEN_W'(FREE_SLOTS));
    ctrl.count     = (state_q == S_IDLE) ? in_req_i.count : req_q.count;
    ctrl.free_base = req_q.base_index;
  end

  // Row of free-list cells
  assign chain[0] = '0;
  for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_cell
    entry_t nxt;
    if (i == FREE_SLOTS - 1) begin : g_last
      assign nxt = entry[i];
    end else begin : g_mid
      assign nxt = entry[i+1];
    end
    dia_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .listed_i     (LEN_W'(i) < len_q),
      .append_i     (len_q == LEN_W'(i)),
      .entry_next_i (nxt),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .entry_o      (entry[i]),
      .first_o      (first_vec[i]),
      .exact_o      (exact_vec[i])
    );
  end

  assign any_fit   = chain[FREE_SLOTS].found;
  assign exact_sel = |(first_vec & exact_vec);

  // Base of the picked block, one-hot select
  always_comb begin
    sel_base = '0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      sel_base = sel_base | (entry[i].base & {IDX_W{first_vec[i]}});
    end
  end

  assign bump_sum = {1'b0, bump_q} + {2'b00, req_q.count};

  // Result and list/bump update
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    len_d       = len_q;
    bump_d      = bump_q;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (go) begin
          state_d          = S_IDLE;
          out_valid_d      = 1'b1;
          out_d.alloc_base = IDX_ALL_ONES;
          out_d.status     = ST_OK;
          if (is_alloc) begin
            if (any_fit) begin
              out_d.alloc_base = sel_base;
              if (exact_sel) begin
                len_d = len_q - LEN_W'(1);
              end
            end else if (bump_sum > {2'b00, cap_q}) begin
              out_d.status = ST_EXHAUSTED;
            end else begin
              out_d.alloc_base = bump_q[IDX_W-1:0];
              bump_d           = bump_sum[IDX_W:0];
            end
          end else if (req_q.base_index == IDX_ALL_ONES || req_q.count == '0) begin
            out_d.status = ST_FREE_IGNORED;
          end else if (len_q >= LEN_W'(FREE_SLOTS)) begin
            out_d.status = ST_LIST_FULL;
          end else begin
            len_d = len_q + LEN_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      len_q       <= '0;
      bump_q      <= {1'b0, RESERVED_COUNT_RST};
      cap_q       <= HEAP_CAPACITY_RST;
      rsv_q       <= RESERVED_COUNT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
      bump_q      <= bump_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEAP_CAPACITY: cap_q <= cfg_data_i;
          CFG_RESERVED_COUNT: begin
            rsv_q  <= cfg_data_i;
            len_q  <= '0;
            bump_q <= {1'b0, cfg_data_i};
          end
          default: ;
        endcase
      end
    end
  end

  // Request and response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(FREE_SLOTS))
    else $error("free list length beyond capacity");

  // Fit flags are only meaningful once a compare has been registered
  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(first_vec))
    else $error("more than one first-fit cell");

  a_accept_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_UPD))
    else $error("accepted request did not reach the update cycle");

  a_exact_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && is_alloc && any_fit && exact_sel && !(cfg_we_i && cfg_idx_i == CFG_RESERVED_COUNT))
    |=> (len_q == $past(len_q) - LEN_W'(1)))
    else $error("exact fit did not remove a block");

  a_rsv_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CFG_RESERVED_COUNT) |=> (bump_q == {1'b0, rsv_q}))
    else $error("bump pointer not reloaded");

endmodule

// ===== tb/tb_descriptor_index_allocator.sv =====
`timescale 1ns / 1ps

module tb_descriptor_index_allocator;
  import dia_pkg::*;

  localparam int unsigned FREE_SLOTS = 64;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  dia_req_t             in_req_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  dia_rsp_t             out_rsp_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [IDX_W-1:0]     cfg_data_i = '0;

  // Allocator image: registers, free list and bump pointer
  logic [IDX_W-1:0] heap_cap;
  logic [IDX_W-1:0] blk_base [FREE_SLOTS];
  logic [IDX_W-1:0] blk_size [FREE_SLOTS];
  int unsigned      blk_count;
  logic [IDX_W:0]   bump_ptr;

  dia_req_t    req_backlog_q [$];
  dia_rsp_t    rsp_due_q [$];
  bit          req_taken = 1'b0;
  bit          sender_hold = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;

  descriptor_index_allocator #(
    .FREE_SLOTS(FREE_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the image and return the response it must give
  function automatic dia_rsp_t apply_request(dia_req_t req);
    dia_rsp_t         rsp;
    logic [IDX_W+1:0] bump_sum;
    int               hit;
    int               i;
    rsp.alloc_base = IDX_ALL_ONES;
    rsp.status     = ST_OK;
    if (req.req_type == REQ_ALLOC) begin
      hit = -1;
      for (i = 0; i < int'(blk_count); i++) begin
        if (hit < 0 && blk_size[i] >= req.count) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        rsp.alloc_base = blk_base[hit];
        if (blk_size[hit] == req.count) begin
          // exact fit: later entries close up
          for (i = hit + 1; i < int'(blk_count); i++) begin
            blk_base[i-1] = blk_base[i];
            blk_size[i-1] = blk_size[i];
          end
          blk_count--;
        end else begin
          // base advance wraps within the index width
          blk_base[hit] = blk_base[hit] + req.count;
          blk_size[hit] = blk_size[hit] - req.count;
        end
      end else begin
        bump_sum = bump_ptr + req.count;
        if (bump_sum > heap_cap) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          rsp.alloc_base = bump_ptr[IDX_W-1:0];
          bump_ptr       = bump_sum[IDX_W:0];
        end
      end
    end else if (req.base_index == IDX_ALL_ONES || req.count == '0) begin
      rsp.status = ST_FREE_IGNORED;
    end else if (blk_count >= FREE_SLOTS) begin
      rsp.status = ST_LIST_FULL;
    end else begin
      blk_base[blk_count] = req.base_index;
      blk_size[blk_count] = req.count;
      blk_count++;
    end
    return rsp;
  endfunction

  function automatic logic [IDX_W-1:0] rand_count(int unsigned max_count);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 9) return IDX_W'($urandom());
    if (pick < 11) return IDX_ALL_ONES;
    return IDX_W'($urandom_range(max_count, 1));
  endfunction

  function automatic logic [IDX_W-1:0] rand_base();
    if ($urandom_range(99) < 6) return IDX_ALL_ONES;
    return IDX_W'($urandom());
  endfunction

  task automatic push_req(req_type_e kind, logic [IDX_W-1:0] count,
                          logic [IDX_W-1:0] base);
    dia_req_t req;
    req.req_type   = kind;
    req.count      = count;
    req.base_index = base;
    req_backlog_q = {req_backlog_q, req};
  endtask

  // Mixed traffic; base is randomised on allocates too, where it is ignored
  task automatic push_random(int unsigned n, int unsigned free_pct,
                             int unsigned max_count);
    repeat (n) begin
      push_req(($urandom_range(99) < free_pct) ? REQ_FREE : REQ_ALLOC,
               rand_count(max_count), rand_base());
    end
  endtask

  // Run of well-formed frees, long enough to overflow the list
  task automatic push_free_burst(int unsigned n, int unsigned max_count);
    repeat (n) begin
      push_req(REQ_FREE, IDX_W'($urandom_range(max_count, 1)),
               IDX_W'($urandom_range(IDX_ALL_ONES - 1, 0)));
    end
  endtask

  // Hold until every request has been answered
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (req_backlog_q.size() != 0 || in_valid_i || rsp_due_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HEAP_CAPACITY: heap_cap = value;
      CFG_RESERVED_COUNT: begin
        blk_count = 0;
        bump_ptr  = {1'b0, value};
      end
      default: ;
    endcase
  endtask

  // Request driver and response stall, both changing on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (req_backlog_q.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i   <= req_backlog_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Response check, then prediction for a request taken at this edge
  always @(posedge clk_i) begin
    dia_rsp_t due;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rsp_due_q.size() == 0) begin
          $display("%0t: unexpected response base=%h status=%0d", $time,
                   out_rsp_o.alloc_base, out_rsp_o.status);
          error_count++;
        end else begin
          due = rsp_due_q.pop_front();
          if (out_rsp_o.alloc_base !== due.alloc_base) begin
            $display("%0t: alloc_base expected %h got %h", $time,
                     due.alloc_base, out_rsp_o.alloc_base);
            error_count++;
          end
          if (out_rsp_o.status !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     due.status, out_rsp_o.status);
            error_count++;
          end
        end
      end
      req_taken = in_valid_i && !in_stall_o;
      if (req_taken) begin
        due = apply_request(in_req_i);
        rsp_due_q = {rsp_due_q, due};
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("[descriptor_index_allocator] ERROR");
    $finish;
  end

  initial begin
    heap_cap  = HEAP_CAPACITY_RST;
    blk_count = 0;
    bump_ptr  = {1'b0, RESERVED_COUNT_RST};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, sender idles lightly, receiver heavily
    send_idle_pct = 28;
    recv_idle_pct = 81;
    push_req(REQ_ALLOC, '0, '0);             // zero size, empty list: bump
    push_req(REQ_ALLOC, 20'd1, IDX_ALL_ONES);
    push_req(REQ_ALLOC, IDX_ALL_ONES, '0);   // exhausted
    push_req(REQ_FREE, 20'd5, IDX_ALL_ONES); // invalid base
    push_req(REQ_FREE, '0, 20'h00100);       // zero count
    push_req(REQ_FREE, 20'd8, 20'h00040);
    push_req(REQ_FREE, 20'd4, 20'hffffe);
    push_req(REQ_ALLOC, '0, '0);             // zero size hits first block
    push_req(REQ_ALLOC, 20'd3, '0);          // partial take
    push_req(REQ_ALLOC, 20'd5, '0);          // exact fit, list closes up
    push_req(REQ_ALLOC, 20'd2, '0);          // base advance wraps to zero
    push_req(REQ_ALLOC, 20'd2, '0);
    push_req(REQ_ALLOC, 20'd1022, '0);       // bump up to capacity exactly
    push_req(REQ_ALLOC, 20'd1, '0);
    push_req(REQ_ALLOC, '0, '0);             // bump at capacity, zero size
    push_req(REQ_FREE, IDX_ALL_ONES, '0);
    push_req(REQ_ALLOC, IDX_ALL_ONES, '0);
    push_req(REQ_FREE, 20'haaaaa, 20'h55555);
    push_free_burst(70, 16);
    push_random(110, 45, 16);
    wait_drained();

    // Widest heap, nothing reserved
    write_reg(CFG_HEAP_CAPACITY, IDX_ALL_ONES);
    write_reg(CFG_RESERVED_COUNT, '0);
    push_req(REQ_ALLOC, IDX_ALL_ONES, '0);
    push_req(REQ_ALLOC, '0, '0);
    push_req(REQ_ALLOC, 20'd1, '0);
    push_random(100, 50, 4096);
    // sender pauses here until every outstanding response is back
    sender_hold = 1'b1;
    do begin
      @(posedge clk_i);
    end while (in_valid_i || rsp_due_q.size() != 0);
    sender_hold = 1'b0;
    push_random(50, 40, IDX_ALL_ONES);
    wait_drained();

    // Reserved slots beyond capacity; receiver now idles lightly
    send_idle_pct = 81;
    recv_idle_pct = 28;
    write_reg(CFG_HEAP_CAPACITY, 20'd1);
    write_reg(CFG_RESERVED_COUNT, IDX_ALL_ONES);
    push_req(REQ_ALLOC, '0, '0);
    push_req(REQ_FREE, 20'd2, 20'd3);
    push_req(REQ_ALLOC, 20'd1, '0);
    push_random(60, 50, 8);
    wait_drained();

    // Small heap, then capacity alone changed with the list kept
    write_reg(CFG_HEAP_CAPACITY, 20'd48);
    write_reg(CFG_RESERVED_COUNT, 20'd5);
    push_random(100, 40, 6);
    wait_drained();
    write_reg(CFG_HEAP_CAPACITY, 20'd200);
    push_random(50, 40, 6);
    wait_drained();

    // Back to reset values, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SPARE, IDX_W'($urandom()));
    write_reg(CFG_HEAP_CAPACITY, HEAP_CAPACITY_RST);
    write_reg(CFG_RESERVED_COUNT, RESERVED_COUNT_RST);
    push_free_burst(66, 32);
    push_random(70, 30, 32);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (rsp_due_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, rsp_due_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[descriptor_index_allocator] OK");
    end else begin
      $display("[descriptor_index_allocator] ERROR");
    end
    $finish;
  end

endmodule
